FILE: rtl/lpsc_pkg.sv
// lpsc_pkg: shared types and constants of the length-prefixed to start-code converter
// used by lpsc_parse and length_prefixed_to_start_code_core; no dependencies
`default_nettype none

package lpsc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenSizeW  = 3;
  localparam int unsigned LenW      = 32;
  localparam int unsigned SeenW     = 3;
  localparam int unsigned ScBytes   = 4;
  localparam int unsigned BeatW     = 2;

  localparam logic [LenSizeW-1:0] LenSizeReset = LenSizeW'(4);
  localparam logic [LenSizeW-1:0] LenSizeMin   = LenSizeW'(1);
  localparam logic [LenSizeW-1:0] LenSizeMax   = LenSizeW'(4);
  localparam logic [BeatW-1:0]    ScLastBeat   = BeatW'(ScBytes - 1);
  localparam logic [ByteW-1:0]    ScZeroByte   = ByteW'(8'h00);
  localparam logic [ByteW-1:0]    ScOneByte    = ByteW'(8'h01);

  // what a pending result burst carries
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,  // one payload byte
    KIND_START = 2'd1,  // four start-code beats
    KIND_MARK  = 2'd2   // one truncation marker
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] data;
    logic             last;
    logic             trunc;
  } desc_t;

endpackage

`default_nettype wire

FILE: rtl/lpsc_parse.sv
// lpsc_parse: parse state of the converter; turns one input byte into at most one result burst
// depends on lpsc_pkg
`default_nettype none

module lpsc_parse (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [lpsc_pkg::LenSizeW-1:0] cfg_len_size,
  input  wire logic                          step,
  input  wire logic [lpsc_pkg::ByteW-1:0]    data_byte,
  input  wire logic                          last_in_sample,
  output lpsc_pkg::desc_t                    desc,
  output logic                               desc_has
);
  import lpsc_pkg::*;

  logic [LenSizeW-1:0] len_size_r;
  logic                in_payload_r, in_payload_nxt;
  logic [SeenW-1:0]    seen_r, seen_nxt;
  logic [LenW-1:0]     acc_r, acc_nxt;
  logic [LenW-1:0]     rem_r, rem_nxt;

  logic [LenSizeW-1:0] eff_size;
  logic [LenW-1:0]     acc_sh;
  logic [SeenW-1:0]    seen_inc;
  logic [LenW-1:0]     rem_dec;
  logic                field_done;

  // length size register, out-of-range codes clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_size_r <= LenSizeReset;
    end else if (cfg_we) begin
      len_size_r <= cfg_len_size;
    end
  end

  always_comb begin
    if (len_size_r < LenSizeMin) begin
      eff_size = LenSizeMin;
    end else if (len_size_r > LenSizeMax) begin
      eff_size = LenSizeMax;
    end else begin
      eff_size = len_size_r;
    end
  end

  assign acc_sh     = {acc_r[LenW-ByteW-1:0], data_byte};
  assign seen_inc   = seen_r + SeenW'(1);
  assign rem_dec    = rem_r - LenW'(1);
  assign field_done = seen_inc >= eff_size;

  // next parse state and the burst this byte causes
  always_comb begin
    in_payload_nxt = in_payload_r;
    seen_nxt       = seen_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    desc.kind      = KIND_PASS;
    desc.data      = data_byte;
    desc.last      = last_in_sample;
    desc.trunc     = 1'b0;
    desc_has       = 1'b0;
    if (in_payload_r) begin
      rem_nxt        = rem_dec;
      in_payload_nxt = (rem_dec != '0);
      desc.trunc     = last_in_sample && (rem_dec != '0);
      desc_has       = 1'b1;
    end else if (field_done) begin
      desc.kind      = KIND_START;
      desc.trunc     = last_in_sample && (acc_sh != '0);
      desc_has       = 1'b1;
      rem_nxt        = acc_sh;
      in_payload_nxt = (acc_sh != '0);
      acc_nxt        = '0;
      seen_nxt       = '0;
    end else begin
      acc_nxt  = acc_sh;
      seen_nxt = seen_inc;
      if (last_in_sample) begin
        desc.kind  = KIND_MARK;
        desc.data  = '0;
        desc.trunc = 1'b1;
        desc_has   = 1'b1;
      end
    end
    // end of sample always returns to length reading
    if (last_in_sample) begin
      in_payload_nxt = 1'b0;
      seen_nxt       = '0;
      acc_nxt        = '0;
      rem_nxt        = '0;
    end
  end

  // parse state update on each consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      seen_r       <= '0;
      acc_r        <= '0;
      rem_r        <= '0;
    end else if (step) begin
      in_payload_r <= in_payload_nxt;
      seen_r       <= seen_nxt;
      acc_r        <= acc_nxt;
      rem_r        <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/length_prefixed_to_start_code_core.sv
// length_prefixed_to_start_code_core: top level of the length-prefixed to start-code converter
// depends on lpsc_pkg and lpsc_parse
// path: an accepted input beat goes through the input register, then the result register,
//   before its first result beat
// throughput: one input beat per cycle while out_tready is high and each byte yields at most
//   one result beat; a start code holds the result register for four beats, so the
//   next byte waits for its final beat after every completed length field, whatever its size
// reset: synchronous active-low rst_n clears the parse state, both valid flags and the beat
//   counter and sets length_size to 4
`default_nettype none

module length_prefixed_to_start_code_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lpsc_pkg::LenSizeW-1:0] cfg_data,   // length_size
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  wire logic                          in_tlast,   // last_in_sample
  // result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] out_byte
  output logic                               out_tlast,  // out_last
  output logic                               out_tuser   // [0] truncated
);
  import lpsc_pkg::*;

  logic             in_vld_r;
  logic [ByteW-1:0] in_byte_r;
  logic             in_last_r;

  logic             res_vld_r;
  desc_t            res_r;
  logic [BeatW-1:0] beat_r;

  desc_t            pdesc;
  logic             pdesc_has;
  logic             final_beat;
  logic             res_free;
  logic             advance;

  assign cfg_ready = 1'b1;

  // result register frees when empty or its last beat is taken
  assign final_beat = (res_r.kind != KIND_START) || (beat_r == ScLastBeat);
  assign res_free   = !res_vld_r || (out_tready && final_beat);
  assign advance    = in_vld_r && res_free;
  assign in_tready  = !in_vld_r || res_free;

  lpsc_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_len_size   (cfg_data),
    .step           (advance),
    .data_byte      (in_byte_r),
    .last_in_sample (in_last_r),
    .desc           (pdesc),
    .desc_has       (pdesc_has)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // result register and start-code beat counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
      beat_r    <= '0;
    end else if (res_free) begin
      res_vld_r <= advance && pdesc_has;
      beat_r    <= '0;
    end else if (out_tready) begin
      beat_r <= beat_r + BeatW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pdesc_has) begin
      res_r <= pdesc;
    end
  end

  // result beat fields
  always_comb begin
    out_tvalid = res_vld_r;
    unique case (res_r.kind)
      KIND_START: begin
        out_tdata = final_beat ? ScOneByte : ScZeroByte;
        out_tlast = final_beat && res_r.last;
        out_tuser = final_beat && res_r.trunc;
      end
      KIND_PASS, KIND_MARK: begin
        out_tdata = res_r.data;
        out_tlast = res_r.last;
        out_tuser = res_r.trunc;
      end
      default: begin
        out_tdata = res_r.data;
        out_tlast = res_r.last;
        out_tuser = res_r.trunc;
      end
    endcase
  end

  // checks
  a_beat_only_start: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && (beat_r != '0) |-> (res_r.kind == KIND_START))
    else $error("beat counter moved on a single-beat result");

  a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("truncated flag without end of sample");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> final_beat)
    else $error("end of sample flagged before the final start-code beat");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !res_free |=> in_vld_r && $stable(in_byte_r) && $stable(in_last_r))
    else $error("pending input byte lost while the result stalled");

endmodule

`default_nettype wire
